FILE: rtl/pwve_pkg.sv
package pwve_pkg;

  typedef enum logic [1:0] {
    MODE_INACTIVE = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_DECAY    = 2'd2
  } voice_mode_t;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_NOTE_ON  = 2'd1,
    FUNC_NOTE_OFF = 2'd2,
    FUNC_TABLE_WR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    REG_ATTACK = 2'd0,
    REG_DECAY  = 2'd1,
    REG_MASTER = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ON_RD,
    ST_ON_CMP,
    ST_ON_WR,
    ST_OFF_RD,
    ST_OFF_WR,
    ST_TK_RD,
    ST_TK_WAVE,
    ST_TK_MIX,
    ST_TK_WAIT,
    ST_TK_OUT
  } state_t;

  typedef struct packed {
    voice_mode_t mode;
    logic [7:0]  note;
    logic [31:0] age;
    logic [31:0] phase;
    logic [31:0] step;
    logic [31:0] level;
  } voice_t;

  localparam logic [31:0] GAIN_FLOOR    = 32'd43;
  localparam logic [32:0] UNITY         = 33'h1_0000_0000;
  localparam logic [31:0] LEVEL_FULL    = 32'hFFFF_FFFF;
  localparam logic [7:0]  NOTE_VALID    = 8'h80;
  localparam logic [31:0] AGE_START     = 32'd32;
  localparam logic [31:0] ATTACK_RESET  = 32'd4233600000;
  localparam logic [31:0] DECAY_RESET   = 32'd4278500000;
  localparam logic [15:0] MASTER_RESET  = 16'd4096;
  localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
  localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

endpackage

FILE: rtl/pwve_if.sv
interface pwve_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [6:0]  note;
  logic [31:0] phase_step;
  logic        table_channel;
  logic [9:0]  table_index;
  logic signed [15:0] table_value;

  modport source (output valid, func, note, phase_step, table_channel, table_index,
                  table_value, input ready);
  modport sink (input valid, func, note, phase_step, table_channel, table_index,
                table_value, output ready);
endinterface

interface pwve_out_if;
  logic        valid;
  logic        ready;
  logic signed [23:0] left_sample;
  logic signed [23:0] right_sample;

  modport source (output valid, left_sample, right_sample, input ready);
  modport sink (input valid, left_sample, right_sample, output ready);
endinterface

FILE: rtl/polyphonic_wavetable_voice_engine.sv
// Polyphonic wavetable voice engine. Voice state (mode, note, age, phase, step, gain)
// lives in one synchronous RAM walked by a sequencer; the two wavetables are separate
// RAMs. After reset a clearing pass initializes the voice RAM while cmd.ready
// stays low. Note-on and note-off walk every voice once; a tick walks every voice
// with a read, a table read and, for a sounding voice, the two-stage multiply;
// one stereo sample is produced per tick, none otherwise.
// Wavetable entries must be written before a sounding voice reads them.
module polyphonic_wavetable_voice_engine import pwve_pkg::*; #(
  parameter int NUM_VOICES = 32,
  parameter int TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  pwve_in_if.sink     cmd,
  pwve_out_if.source  res
);

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = VW + 1;
  localparam int TW = $clog2(TABLE_SIZE);

  state_t state, state_next;

  logic [31:0] attack, decay;
  logic [15:0] mgain;
  logic [31:0] age_counter;
  logic [CW-1:0] idx;
  logic [6:0]  note_q;
  logic [31:0] step_q;
  voice_t      rec;
  logic signed [31:0] acc_l, acc_r;
  logic        out_valid;
  logic signed [23:0] out_l, out_r;

  logic [2:0]    found;
  logic [VW-1:0] best_idx [3];
  logic [31:0]   best_age [3];

  logic          vwe;
  logic [VW-1:0] vwaddr;
  voice_t        vwdata, vrdata;

  logic          last;
  logic          accept;
  logic [31:0]   ti32;
  logic [45:0]   posp;
  logic [TW-1:0] pos;
  logic          tw_ok;
  logic signed [15:0] wl_rd, wr_rd;

  logic          mix_done;
  voice_t        mix_rec;
  logic signed [24:0] cl, cr;

  assign last   = (idx == CW'(NUM_VOICES - 1));
  assign accept = cmd.valid && cmd.ready;
  assign ti32   = 32'(cmd.table_index);
  assign tw_ok  = accept && (func_t'(cmd.func) == FUNC_TABLE_WR) &&
                  (ti32 < 32'(TABLE_SIZE));
  // address the tables from the voice word as it leaves the RAM
  assign posp   = 46'(vrdata.phase) * 46'(TABLE_SIZE);
  assign pos    = posp[32 +: TW];

  assign cmd.ready        = (state == ST_IDLE);
  assign res.valid        = out_valid;
  assign res.left_sample  = out_l;
  assign res.right_sample = out_r;

  pwve_ram #(.WIDTH($bits(voice_t)), .DEPTH(NUM_VOICES)) u_voice_ram (
    .clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
    .raddr(idx[VW-1:0]), .rdata(vrdata)
  );

  pwve_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_wave_l (
    .clk(clk), .we(tw_ok && !cmd.table_channel), .waddr(ti32[TW-1:0]),
    .wdata(cmd.table_value), .raddr(pos), .rdata(wl_rd)
  );

  pwve_ram #(.WIDTH(16), .DEPTH(TABLE_SIZE)) u_wave_r (
    .clk(clk), .we(tw_ok && cmd.table_channel), .waddr(ti32[TW-1:0]),
    .wdata(cmd.table_value), .raddr(pos), .rdata(wr_rd)
  );

  pwve_mix u_mix (
    .clk(clk), .rst(rst), .start(state == ST_TK_MIX), .rec_in(rec),
    .entry_l(wl_rd), .entry_r(wr_rd), .attack(attack), .decay(decay), .mgain(mgain),
    .done(mix_done), .rec_out(mix_rec), .contrib_l(cl), .contrib_r(cr)
  );

  // voice RAM write port and next state
  always_comb begin
    state_next = state;
    vwe        = 1'b0;
    vwaddr     = idx[VW-1:0];
    vwdata     = vrdata;
    case (state)
      ST_CLEAR: begin
        vwe          = 1'b1;
        vwdata       = '0;
        vwdata.mode  = MODE_INACTIVE;
        vwdata.age   = 32'(idx);
        if (last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (func_t'(cmd.func))
            FUNC_TICK:     state_next = ST_TK_RD;
            FUNC_NOTE_ON:  state_next = ST_ON_RD;
            FUNC_NOTE_OFF: state_next = ST_OFF_RD;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_ON_RD:  state_next = ST_ON_CMP;
      ST_ON_CMP: state_next = last ? ST_ON_WR : ST_ON_RD;
      ST_ON_WR: begin
        vwe         = 1'b1;
        vwaddr      = found[0] ? best_idx[0] : found[2] ? best_idx[2] :
                      found[1] ? best_idx[1] : '0;
        vwdata.mode = MODE_ACTIVE;
        vwdata.note = NOTE_VALID | {1'b0, note_q};
        vwdata.age  = age_counter;
        vwdata.phase = '0;
        vwdata.step  = step_q;
        vwdata.level = GAIN_FLOOR;
        state_next  = ST_IDLE;
      end
      ST_OFF_RD: state_next = ST_OFF_WR;
      ST_OFF_WR: begin
        vwe = 1'b1;
        if (vrdata.note == (NOTE_VALID | {1'b0, note_q})) begin
          vwdata.mode = MODE_DECAY;
        end
        state_next = last ? ST_IDLE : ST_OFF_RD;
      end
      ST_TK_RD: state_next = ST_TK_WAVE;
      ST_TK_WAVE: begin
        if (vrdata.mode == MODE_INACTIVE) begin
          state_next = last ? ST_TK_OUT : ST_TK_RD;
        end else begin
          state_next = ST_TK_MIX;
        end
      end
      ST_TK_MIX: state_next = ST_TK_WAIT;
      ST_TK_WAIT: begin
        if (mix_done) begin
          vwe        = 1'b1;
          vwdata     = mix_rec;
          state_next = last ? ST_TK_OUT : ST_TK_RD;
        end
      end
      ST_TK_OUT: begin
        if (!out_valid || res.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > OUT_MAX) return OUT_MAX[23:0];
    if (v < OUT_MIN) return OUT_MIN[23:0];
    return v[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      attack      <= ATTACK_RESET;
      decay       <= DECAY_RESET;
      mgain       <= MASTER_RESET;
      age_counter <= AGE_START;
      idx         <= '0;
      out_valid   <= 1'b0;
      found       <= '0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_ATTACK: attack <= cfg_data;
          REG_DECAY:  decay  <= cfg_data;
          REG_MASTER: mgain  <= cfg_data[15:0];
          default:    ;
        endcase
      end
      if (state == ST_TK_OUT && (!out_valid || res.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: idx <= last ? '0 : idx + 1'b1;
        ST_IDLE: begin
          idx    <= '0;
          found  <= '0;
          note_q <= cmd.note;
          step_q <= cmd.phase_step;
          acc_l  <= '0;
          acc_r  <= '0;
        end
        ST_ON_CMP: begin
          // keep first-found on ties: strict compare in ascending order
          for (int m = 0; m < 3; m++) begin
            if (vrdata.mode == voice_mode_t'(m) &&
                (!found[m] || vrdata.age < best_age[m])) begin
              found[m]    <= 1'b1;
              best_idx[m] <= idx[VW-1:0];
              best_age[m] <= vrdata.age;
            end
          end
          idx <= idx + 1'b1;
        end
        ST_ON_WR:  age_counter <= age_counter + 32'd1;
        ST_OFF_WR: idx <= idx + 1'b1;
        ST_TK_WAVE: begin
          rec <= vrdata;
          if (vrdata.mode == MODE_INACTIVE) idx <= idx + 1'b1;
        end
        ST_TK_WAIT: begin
          if (mix_done) begin
            acc_l <= acc_l + 32'(cl);
            acc_r <= acc_r + 32'(cr);
            idx   <= idx + 1'b1;
          end
        end
        ST_TK_OUT: begin
          if (!out_valid || res.ready) begin
            out_l     <= sat24(acc_l);
            out_r     <= sat24(acc_r);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/pwve_ram.sv
module pwve_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/pwve_mix.sv
module pwve_mix import pwve_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  voice_t             rec_in,
  input  logic signed [15:0] entry_l,
  input  logic signed [15:0] entry_r,
  input  logic [31:0]        attack,
  input  logic [31:0]        decay,
  input  logic [15:0]        mgain,
  output logic               done,
  output voice_t             rec_out,
  output logic signed [24:0] contrib_l,
  output logic signed [24:0] contrib_r
);

  logic               v1;
  voice_t             rec1;
  logic [32:0]        g1;
  logic signed [32:0] em_l1, em_r1;
  logic [65:0]        lp1;
  logic               att1, dec1;

  logic [32:0]        g;
  logic               att, dec;
  logic [32:0]        opa, opb;
  logic signed [32:0] em_l, em_r;

  always_comb begin
    g    = (rec_in.level == LEVEL_FULL) ? UNITY : {1'b0, rec_in.level};
    att  = (rec_in.mode == MODE_ACTIVE) && !g[32];
    dec  = (rec_in.mode == MODE_DECAY);
    opa  = att ? {1'b0, attack} : g;
    opb  = att ? (UNITY - g) : {1'b0, decay};
    em_l = entry_l * $signed({1'b0, mgain});
    em_r = entry_r * $signed({1'b0, mgain});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
    if (start) begin
      rec1  <= rec_in;
      g1    <= g;
      em_l1 <= em_l;
      em_r1 <= em_r;
      lp1   <= opa * opb;
      att1  <= att;
      dec1  <= dec;
    end
  end

  logic signed [66:0] full_l, full_r;
  logic [32:0]        p;
  voice_t             rec2;

  always_comb begin
    full_l = em_l1 * $signed({1'b0, g1});
    full_r = em_r1 * $signed({1'b0, g1});
    p      = lp1[64:32];
    rec2   = rec1;
    rec2.phase = rec1.phase + rec1.step;
    if (att1) begin
      rec2.level = (p == 33'd0) ? LEVEL_FULL : 32'(UNITY - p);
    end else if (dec1) begin
      rec2.level = lp1[63:32];
      if (p < {1'b0, GAIN_FLOOR}) begin
        rec2.mode = MODE_INACTIVE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    if (v1) begin
      rec_out   <= rec2;
      contrib_l <= full_l[66:42];
      contrib_r <= (rec2.mode == MODE_INACTIVE) ? 25'sd0 : full_r[66:42];
    end
  end

endmodule

FILE: test/polyphonic_wavetable_voice_engine_tb.sv
`timescale 1ns / 1ps

module polyphonic_wavetable_voice_engine_tb;
  import pwve_pkg::*;

  localparam int VOICES = 32;
  localparam int TBL = 1024;
  // phase steps keep their low 26 bits zero, so voices only read every 16th entry
  localparam int ENTRY_STRIDE = 16;
  localparam int SETTLE = 5 * VOICES + 40;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    func_t             func;
    logic [6:0]        note;
    logic [31:0]       step;
    logic              chan;
    logic [9:0]        idx;
    logic signed [15:0] value;
  } synth_cmd_t;

  typedef struct {
    logic signed [23:0] left;
    logic signed [23:0] right;
  } stereo_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  pwve_in_if cmd_if ();
  pwve_out_if res_if ();

  polyphonic_wavetable_voice_engine u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_if),
    .res(res_if)
  );

  // model of the voice bank
  voice_mode_t        mdl_mode[VOICES];
  logic [7:0]         mdl_note[VOICES];
  logic [31:0]        mdl_age[VOICES];
  logic [31:0]        mdl_phase[VOICES];
  logic [31:0]        mdl_step[VOICES];
  logic [31:0]        mdl_level[VOICES];
  logic [31:0]        mdl_age_ctr;
  logic signed [15:0] mdl_wave[2][TBL];
  logic [31:0]        mdl_attack;
  logic [31:0]        mdl_decay;
  logic [15:0]        mdl_master;

  stereo_t expected_samples[$];
  int errors = 0;
  int cycles = 0;
  int hold_len = 0;
  bit quiet = 0;
  logic [6:0] held_notes[$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("polyphonic_wavetable_voice_engine regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len = hold_len - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= quiet || ($urandom_range(99) >= 14);
    end
  end

  task automatic report(string what, logic signed [23:0] got, logic signed [23:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst && res_if.valid && res_if.ready) begin
      if (expected_samples.size() == 0) begin
        report("unexpected sample", res_if.left_sample, 24'sd0);
      end else begin
        stereo_t want;
        want = expected_samples.pop_front();
        if (res_if.left_sample !== want.left) report("left", res_if.left_sample, want.left);
        if (res_if.right_sample !== want.right)
          report("right", res_if.right_sample, want.right);
      end
    end
  end

  function automatic longint voice_share(logic signed [15:0] entry, logic [32:0] g);
    longint p;
    p = longint'(entry) * longint'(g);
    p = p * longint'(mdl_master);
    return p >>> 42;
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  function automatic int oldest_in(voice_mode_t m);
    int best;
    best = -1;
    for (int i = 0; i < VOICES; i++)
      if (mdl_mode[i] == m && (best < 0 || mdl_age[i] < mdl_age[best])) best = i;
    return best;
  endfunction

  task automatic model_reset();
    for (int i = 0; i < VOICES; i++) begin
      mdl_mode[i] = MODE_INACTIVE;
      mdl_note[i] = 8'd0;
      mdl_age[i] = 32'(i);
      mdl_phase[i] = '0;
      mdl_step[i] = '0;
      mdl_level[i] = '0;
    end
    mdl_age_ctr = AGE_START;
    mdl_attack = ATTACK_RESET;
    mdl_decay = DECAY_RESET;
    mdl_master = MASTER_RESET;
  endtask

  task automatic predict_cmd(synth_cmd_t c);
    int v;
    longint lsum, rsum;
    logic [9:0] pos;
    logic [32:0] g;
    logic [63:0] p, ng;
    stereo_t s;
    case (c.func)
      FUNC_NOTE_ON: begin
        v = oldest_in(MODE_INACTIVE);
        if (v < 0) v = oldest_in(MODE_DECAY);
        if (v < 0) v = oldest_in(MODE_ACTIVE);
        if (v < 0) v = 0;
        mdl_note[v] = NOTE_VALID | {1'b0, c.note};
        mdl_level[v] = GAIN_FLOOR;
        mdl_mode[v] = MODE_ACTIVE;
        mdl_phase[v] = '0;
        mdl_step[v] = c.step;
        mdl_age[v] = mdl_age_ctr;
        mdl_age_ctr = mdl_age_ctr + 1;
      end
      FUNC_NOTE_OFF: begin
        for (int i = 0; i < VOICES; i++)
          if (mdl_note[i] == (NOTE_VALID | {1'b0, c.note})) mdl_mode[i] = MODE_DECAY;
      end
      FUNC_TABLE_WR: mdl_wave[c.chan][c.idx] = c.value;
      default: begin
        lsum = 0;
        rsum = 0;
        for (int i = 0; i < VOICES; i++) begin
          if (mdl_mode[i] != MODE_INACTIVE) begin
            pos = mdl_phase[i][31:22];
            g = (mdl_level[i] == LEVEL_FULL) ? UNITY : {1'b0, mdl_level[i]};
            lsum += voice_share(mdl_wave[0][pos], g);
            if (mdl_mode[i] == MODE_ACTIVE && g < UNITY) begin
              p = (64'(mdl_attack) * 64'(UNITY - g)) >> 32;
              ng = 64'(UNITY) - p;
              mdl_level[i] = (ng >= 64'(UNITY)) ? LEVEL_FULL : ng[31:0];
            end else if (mdl_mode[i] == MODE_DECAY) begin
              ng = (64'(g) * 64'(mdl_decay)) >> 32;
              mdl_level[i] = ng[31:0];
              if (ng < 64'(GAIN_FLOOR)) mdl_mode[i] = MODE_INACTIVE;
            end
            if (mdl_mode[i] != MODE_INACTIVE) rsum += voice_share(mdl_wave[1][pos], g);
            mdl_phase[i] = mdl_phase[i] + mdl_step[i];
          end
        end
        s.left = clip24(lsum);
        s.right = clip24(rsum);
        expected_samples.push_back(s);
      end
    endcase
  endtask

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(synth_cmd_t c);
    if (!quiet && $urandom_range(99) < 14) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.func <= c.func;
    cmd_if.note <= c.note;
    cmd_if.phase_step <= c.step;
    cmd_if.table_channel <= c.chan;
    cmd_if.table_index <= c.idx;
    cmd_if.table_value <= c.value;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_cmd(c);
  endtask

  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t r, logic [31:0] d);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (r)
      REG_ATTACK: mdl_attack = d;
      REG_DECAY:  mdl_decay = d;
      REG_MASTER: mdl_master = d[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] a, logic [31:0] d, logic [15:0] m);
    drain();
    write_reg(REG_ATTACK, a);
    write_reg(REG_DECAY, d);
    write_reg(REG_MASTER, {16'd0, m});
  endtask

  function automatic synth_cmd_t mk(func_t f, logic [6:0] n, logic [31:0] st,
                                    logic ch, logic [9:0] ix, logic [15:0] val);
    synth_cmd_t c;
    c.func = f;
    c.note = n;
    c.step = st;
    c.chan = ch;
    c.idx = ix;
    c.value = val;
    return c;
  endfunction

  function automatic synth_cmd_t random_cmd();
    int r;
    logic [6:0] n;
    r = $urandom_range(99);
    n = ($urandom_range(9) < 7) ? 7'($urandom_range(15)) : 7'($urandom_range(127));
    if (r < 58) return mk(FUNC_TICK, 7'($urandom), $urandom, 1'($urandom), 10'($urandom),
                          16'($urandom));
    if (r < 74) begin
      held_notes.push_back(n);
      return mk(FUNC_NOTE_ON, n,
                ($urandom_range(9) == 0) ? 32'hFC00_0000 : {6'($urandom), 26'd0},
                1'($urandom), 10'($urandom), 16'($urandom));
    end
    if (r < 87) begin
      if (held_notes.size() != 0 && $urandom_range(3) != 0)
        n = held_notes[$urandom_range(held_notes.size() - 1)];
      return mk(FUNC_NOTE_OFF, n, $urandom, 1'($urandom), 10'($urandom), 16'($urandom));
    end
    return mk(FUNC_TABLE_WR, 7'($urandom), $urandom, 1'($urandom), 10'($urandom),
              ($urandom_range(7) == 0) ? (($urandom_range(1) != 0) ? 16'h7FFF : 16'h8000)
                                       : 16'($urandom));
  endfunction

  // load every entry a voice can reach so no voice reads an unwritten one
  task automatic test_table_load();
    for (int ch = 0; ch < 2; ch++)
      for (int i = 0; i < TBL; i += ENTRY_STRIDE)
        send_item(mk(FUNC_TABLE_WR, '0, '0, ch[0], 10'(i), 16'($urandom)));
  endtask

  task automatic test_directed();
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_TABLE_WR, '0, '0, 1'b0, 10'd1023, 16'h7FFF));
    send_item(mk(FUNC_TABLE_WR, '0, '0, 1'b1, 10'd0, 16'h8000));
    send_item(mk(FUNC_NOTE_ON, 7'd127, 32'hFC00_0000, 1'b0, '0, '0));
    send_item(mk(FUNC_NOTE_ON, 7'd0, 32'h0400_0000, 1'b0, '0, '0));
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_NOTE_OFF, 7'd127, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_NOTE_OFF, 7'd5, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
  endtask

  // fill all voices at full gain and full-scale table entries to drive the sums into clipping
  task automatic test_saturation();
    set_regs(32'd0, 32'd0, 16'hFFFF);
    for (int i = 0; i < 2 * VOICES; i += 8) begin
      send_item(mk(FUNC_TABLE_WR, '0, '0, 1'b0, 10'(i), 16'h7FFF));
      send_item(mk(FUNC_TABLE_WR, '0, '0, 1'b1, 10'(i), 16'h8000));
    end
    for (int i = 0; i < VOICES + 3; i++)
      send_item(mk(FUNC_NOTE_ON, 7'(i % 4), '0, 1'b0, '0, '0));
    repeat (3) send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
    // zero decay kills voices after the left sum
    send_item(mk(FUNC_NOTE_OFF, 7'd1, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_NOTE_OFF, 7'd1, '0, 1'b0, '0, '0));
    send_item(mk(FUNC_TICK, '0, '0, 1'b0, '0, '0));
  endtask

  task automatic test_random(int count);
    for (int k = 0; k < count; k++) send_item(random_cmd());
  endtask

  task automatic test_backpressure();
    drain();
    hold_len = 400;
    test_random(60);
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_ATTACK;
    cfg_data <= '0;
    cmd_if.valid <= 1'b0;
    cmd_if.func <= FUNC_TICK;
    cmd_if.note <= '0;
    cmd_if.phase_step <= '0;
    cmd_if.table_channel <= 1'b0;
    cmd_if.table_index <= '0;
    cmd_if.table_value <= '0;
    model_reset();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_load();
    test_directed();
    test_saturation();
    set_regs(ATTACK_RESET, DECAY_RESET, MASTER_RESET);
    test_random(180);
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0);
    test_random(100);
    set_regs($urandom, 32'hF000_0000 | $urandom, 16'($urandom));
    quiet = 1;
    test_random(160);
    quiet = 0;
    test_backpressure();
    set_regs(32'h8000_0000, 32'h4000_0000, 16'hFFFF);
    test_random(140);
    set_regs(ATTACK_RESET, DECAY_RESET, MASTER_RESET);
    test_random(120);

    drain();
    if (errors == 0) begin
      $display("polyphonic_wavetable_voice_engine regression: pass");
    end else begin
      $display("polyphonic_wavetable_voice_engine regression: fail");
    end
    $finish;
  end

endmodule
